FILE: hw/rtl/sst_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the sorted score table.
// Depends on nothing; used by the sequencer, the top level and the checker.
package sst_pkg;

  localparam int unsigned NameW  = 64;
  localparam int unsigned ScoreW = 32;
  localparam int unsigned PosW   = 9;
  localparam int unsigned TotalW = 40;
  localparam int unsigned CapW   = 9;

  localparam logic [CapW-1:0] CapResetVal = 9'd256;

  typedef enum logic [1:0] {
    CMD_INSERT = 2'd0,
    CMD_REMOVE = 2'd1,
    CMD_FIND   = 2'd2,
    CMD_SUM    = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_FULL      = 2'd1,
    ST_NOT_FOUND = 2'd2
  } status_e;

  typedef enum logic [10:0] {
    S_IDLE      = 11'b000_0000_0001,
    S_INS_START = 11'b000_0000_0010,
    S_INS_CMP   = 11'b000_0000_0100,
    S_INS_PUT   = 11'b000_0000_1000,
    S_RM_START  = 11'b000_0001_0000,
    S_RM_SCAN   = 11'b000_0010_0000,
    S_RM_SHIFT  = 11'b000_0100_0000,
    S_FD_RD     = 11'b000_1000_0000,
    S_FD_CMP    = 11'b001_0000_0000,
    S_SUM_START = 11'b010_0000_0000,
    S_SUM_ACC   = 11'b100_0000_0000
  } state_e;

  // One table entry as it is stored in the memory.
  typedef struct packed {
    logic [NameW-1:0]         name;
    logic signed [ScoreW-1:0] score;
  } entry_t;

  localparam int unsigned EntryW = $bits(entry_t);

  // Result of one item, handed from the sequencer to the output register.
  typedef struct packed {
    status_e                  status;
    logic [PosW-1:0]          position;
    logic signed [TotalW-1:0] total;
    logic [PosW-1:0]          entry_count;
  } result_t;

endpackage

FILE: hw/rtl/sst_ram.sv
`timescale 1ns / 1ps
// Generic simple dual-port RAM: one write port, one read port, registered read.
// Depends on nothing.
module sst_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

FILE: hw/rtl/sst_seq.sv
`timescale 1ns / 1ps
// Command sequencer of the sorted score table: walks the entry memory for
// insert, remove, find and sum. Depends on sst_pkg.
module sst_seq #(
  parameter int unsigned MaxEntries = 256
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  sst_pkg::cmd_e                cmd_i,
  input  logic [sst_pkg::NameW-1:0]    name_key_i,
  input  logic signed [sst_pkg::ScoreW-1:0] score_i,
  input  logic [sst_pkg::CapW-1:0]     capacity_i,
  output logic                         busy_o,
  output logic                         done_o,
  output sst_pkg::result_t             result_o,
  output logic                         mem_we_o,
  output logic [$clog2(MaxEntries)-1:0] mem_waddr_o,
  output logic [sst_pkg::EntryW-1:0]   mem_wdata_o,
  output logic [$clog2(MaxEntries)-1:0] mem_raddr_o,
  input  logic [sst_pkg::EntryW-1:0]   mem_rdata_i
);

  localparam int unsigned AW = $clog2(MaxEntries);
  localparam int unsigned CW = $clog2(MaxEntries + 1);
  localparam int unsigned LW = (CW > sst_pkg::CapW) ? CW : sst_pkg::CapW;

  sst_pkg::state_e state_q, state_d;
  logic [sst_pkg::NameW-1:0]         key_q, key_d;
  logic signed [sst_pkg::ScoreW-1:0] score_q, score_d;
  logic [CW-1:0]                     count_q, count_d;
  logic [CW-1:0]                     idx_q, idx_d;
  logic [CW-1:0]                     hi_q, hi_d;
  logic [AW-1:0]                     mid_q, mid_d;
  logic signed [sst_pkg::TotalW-1:0] acc_q, acc_d;

  sst_pkg::entry_t  rd_entry;
  sst_pkg::entry_t  new_entry;
  sst_pkg::result_t res;
  logic             full;
  logic [CW:0]      mid_sum;
  logic signed [sst_pkg::TotalW-1:0] score_ext;

  assign rd_entry  = sst_pkg::entry_t'(mem_rdata_i);
  assign new_entry = '{name: key_q, score: score_q};
  assign full      = (LW'(count_q) >= LW'(capacity_i)) || (count_q >= CW'(MaxEntries));
  assign mid_sum   = {1'b0, idx_q} + {1'b0, hi_q} - 1'b1;
  assign score_ext = {{(sst_pkg::TotalW - sst_pkg::ScoreW){rd_entry.score[sst_pkg::ScoreW-1]}},
                      rd_entry.score};

  always_comb begin
    state_d      = state_q;
    key_d        = key_q;
    score_d      = score_q;
    count_d      = count_q;
    idx_d        = idx_q;
    hi_d         = hi_q;
    mid_d        = mid_q;
    acc_d        = acc_q;
    mem_we_o     = 1'b0;
    mem_waddr_o  = AW'(idx_q);
    mem_wdata_o  = new_entry;
    mem_raddr_o  = '0;
    done_o       = 1'b0;
    res.status   = sst_pkg::ST_OK;
    res.position = '0;
    res.total    = '0;

    case (state_q)
      sst_pkg::S_IDLE: begin
        if (start_i) begin
          key_d   = name_key_i;
          score_d = score_i;
          idx_d   = '0;
          hi_d    = count_q;
          acc_d   = '0;
          case (cmd_i)
            sst_pkg::CMD_INSERT: state_d = sst_pkg::S_INS_START;
            sst_pkg::CMD_REMOVE: state_d = sst_pkg::S_RM_START;
            sst_pkg::CMD_FIND:   state_d = sst_pkg::S_FD_RD;
            sst_pkg::CMD_SUM:    state_d = sst_pkg::S_SUM_START;
            default:             state_d = sst_pkg::S_IDLE;
          endcase
        end
      end

      sst_pkg::S_INS_START: begin
        if (full) begin
          res.status = sst_pkg::ST_FULL;
          done_o     = 1'b1;
          state_d    = sst_pkg::S_IDLE;
        end else if (count_q == '0) begin
          idx_d   = '0;
          state_d = sst_pkg::S_INS_PUT;
        end else begin
          idx_d       = count_q;
          mem_raddr_o = AW'(count_q - 1'b1);
          state_d     = sst_pkg::S_INS_CMP;
        end
      end

      // Read data holds the entry just above the hole at idx.
      sst_pkg::S_INS_CMP: begin
        if (score_q > rd_entry.score) begin
          mem_we_o    = 1'b1;
          mem_waddr_o = AW'(idx_q);
          mem_wdata_o = rd_entry;
          idx_d       = idx_q - 1'b1;
          if (idx_q != CW'(1)) begin
            mem_raddr_o = AW'(idx_q - CW'(2));
          end else begin
            state_d = sst_pkg::S_INS_PUT;
          end
        end else begin
          mem_we_o     = 1'b1;
          mem_waddr_o  = AW'(idx_q);
          count_d      = count_q + 1'b1;
          res.position = sst_pkg::PosW'(idx_q + 1);
          done_o       = 1'b1;
          state_d      = sst_pkg::S_IDLE;
        end
      end

      sst_pkg::S_INS_PUT: begin
        mem_we_o     = 1'b1;
        mem_waddr_o  = AW'(idx_q);
        count_d      = count_q + 1'b1;
        res.position = sst_pkg::PosW'(idx_q + 1);
        done_o       = 1'b1;
        state_d      = sst_pkg::S_IDLE;
      end

      sst_pkg::S_RM_START: begin
        if (count_q == '0) begin
          res.status = sst_pkg::ST_NOT_FOUND;
          done_o     = 1'b1;
          state_d    = sst_pkg::S_IDLE;
        end else begin
          mem_raddr_o = '0;
          idx_d       = '0;
          state_d     = sst_pkg::S_RM_SCAN;
        end
      end

      // Read data holds entry idx; the next entry is fetched ahead.
      sst_pkg::S_RM_SCAN: begin
        mem_raddr_o = AW'(idx_q + 1'b1);
        if (rd_entry.name == key_q) begin
          res.position = sst_pkg::PosW'(idx_q + 1);
          if (CW'(idx_q + 1'b1) < count_q) begin
            // The removed position is kept in hi while the tail moves up.
            hi_d    = CW'(idx_q + 1'b1);
            state_d = sst_pkg::S_RM_SHIFT;
          end else begin
            count_d = count_q - 1'b1;
            done_o  = 1'b1;
            state_d = sst_pkg::S_IDLE;
          end
        end else if (CW'(idx_q + 1'b1) < count_q) begin
          idx_d = idx_q + 1'b1;
        end else begin
          res.status = sst_pkg::ST_NOT_FOUND;
          done_o     = 1'b1;
          state_d    = sst_pkg::S_IDLE;
        end
      end

      // Read data holds entry idx+1, which moves up into idx.
      sst_pkg::S_RM_SHIFT: begin
        mem_we_o    = 1'b1;
        mem_waddr_o = AW'(idx_q);
        mem_wdata_o = rd_entry;
        mem_raddr_o = AW'(idx_q + CW'(2));
        idx_d       = idx_q + 1'b1;
        if (CW'(idx_q + CW'(2)) >= count_q) begin
          count_d      = count_q - 1'b1;
          res.position = sst_pkg::PosW'(hi_q);
          done_o       = 1'b1;
          state_d      = sst_pkg::S_IDLE;
        end
      end

      // Binary search over [idx, hi); idx is the low bound.
      sst_pkg::S_FD_RD: begin
        if (idx_q < hi_q) begin
          mid_d       = AW'(mid_sum >> 1);
          mem_raddr_o = AW'(mid_sum >> 1);
          state_d     = sst_pkg::S_FD_CMP;
        end else begin
          res.status = sst_pkg::ST_NOT_FOUND;
          done_o     = 1'b1;
          state_d    = sst_pkg::S_IDLE;
        end
      end

      sst_pkg::S_FD_CMP: begin
        if (score_q == rd_entry.score) begin
          res.position = sst_pkg::PosW'(mid_q + 1);
          done_o       = 1'b1;
          state_d      = sst_pkg::S_IDLE;
        end else begin
          if (score_q < rd_entry.score) begin
            idx_d = CW'(mid_q) + 1'b1;
          end else begin
            hi_d = CW'(mid_q);
          end
          state_d = sst_pkg::S_FD_RD;
        end
      end

      sst_pkg::S_SUM_START: begin
        if (count_q == '0) begin
          done_o  = 1'b1;
          state_d = sst_pkg::S_IDLE;
        end else begin
          mem_raddr_o = '0;
          idx_d       = '0;
          state_d     = sst_pkg::S_SUM_ACC;
        end
      end

      sst_pkg::S_SUM_ACC: begin
        acc_d       = acc_q + score_ext;
        mem_raddr_o = AW'(idx_q + 1'b1);
        if (CW'(idx_q + 1'b1) < count_q) begin
          idx_d = idx_q + 1'b1;
        end else begin
          res.total = acc_q + score_ext;
          done_o    = 1'b1;
          state_d   = sst_pkg::S_IDLE;
        end
      end

      default: begin
        state_d = sst_pkg::S_IDLE;
      end
    endcase

    res.entry_count = sst_pkg::PosW'(count_d);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= sst_pkg::S_IDLE;
      count_q <= '0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    key_q   <= key_d;
    score_q <= score_d;
    idx_q   <= idx_d;
    hi_q    <= hi_d;
    mid_q   <= mid_d;
    acc_q   <= acc_d;
  end

  assign busy_o   = (state_q != sst_pkg::S_IDLE);
  assign result_o = res;

endmodule

FILE: hw/rtl/sorted_score_table_top.sv
`timescale 1ns / 1ps
// Top level of the sorted score table: capacity register, result register,
// sequencer and entry memory. Depends on sst_pkg, sst_seq and sst_ram.
//
//   channel   | signals                                   | accepted when
//   ----------+-------------------------------------------+------------------------
//   command   | start_i, busy_o, command_i, name_key_i,   | start_i high, busy_o low
//             | score_i                                   |
//   result    | valid_o, status_o, position_o, total_o,   | every cycle valid_o high
//             | entry_count_o                             |
//   config    | cfg_valid_i, cfg_ready_o, cfg_data_i      | cfg_valid_i and cfg_ready_o
//
// An insert shifts lower-scored entries down one at a time and then writes the
// new entry (a full table is refused at once), a remove scans for the name and
// then moves the entries after it up, a find halves the search range at each
// step until the score matches or the range is empty, and a sum adds every
// entry in turn. The entry memory's single read port gives one entry per cycle.
// The result shows on valid_o for one cycle, the same cycle in which busy_o
// falls, so the next item may be accepted at that edge. The receiver cannot
// stall. Reset empties the table and sets capacity to 256; the memory itself
// is not cleared, since only entries below the fill count are ever used.
module sorted_score_table_top #(
  parameter int unsigned MaxEntries = 256
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               start_i,
  output logic                               busy_o,
  input  logic [1:0]                         command_i,
  input  logic [sst_pkg::NameW-1:0]          name_key_i,
  input  logic signed [sst_pkg::ScoreW-1:0]  score_i,
  output logic                               valid_o,
  output logic [1:0]                         status_o,
  output logic [sst_pkg::PosW-1:0]           position_o,
  output logic signed [sst_pkg::TotalW-1:0]  total_o,
  output logic [sst_pkg::PosW-1:0]           entry_count_o,
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic [sst_pkg::CapW-1:0]           cfg_data_i
);

  localparam int unsigned AW = $clog2(MaxEntries);

  logic [sst_pkg::CapW-1:0] capacity_q;
  logic                     valid_q;
  sst_pkg::result_t         result_q;

  logic                     seq_done;
  logic                     seq_busy;
  sst_pkg::result_t         seq_result;
  logic                     mem_we;
  logic [AW-1:0]            mem_waddr;
  logic [AW-1:0]            mem_raddr;
  logic [sst_pkg::EntryW-1:0] mem_wdata;
  logic [sst_pkg::EntryW-1:0] mem_rdata;

  // The capacity register is always ready; the user must write it only while idle, which the block does not enforce.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      capacity_q <= sst_pkg::CapResetVal;
      valid_q    <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        capacity_q <= cfg_data_i;
      end
      valid_q <= seq_done;
    end
  end

  // The result register holds its value until the next item completes.
  always_ff @(posedge clk_i) begin
    if (seq_done) begin
      result_q <= seq_result;
    end
  end

  sst_seq #(
    .MaxEntries (MaxEntries)
  ) u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start_i),
    .cmd_i       (sst_pkg::cmd_e'(command_i)),
    .name_key_i  (name_key_i),
    .score_i     (score_i),
    .capacity_i  (capacity_q),
    .busy_o      (seq_busy),
    .done_o      (seq_done),
    .result_o    (seq_result),
    .mem_we_o    (mem_we),
    .mem_waddr_o (mem_waddr),
    .mem_wdata_o (mem_wdata),
    .mem_raddr_o (mem_raddr),
    .mem_rdata_i (mem_rdata)
  );

  // Name and score of an entry share one word, so every shift step is a
  // single read and a single write. When the write address equals the address
  // read in the same cycle, that read data is never used, so no forwarding is needed.
  sst_ram #(
    .Width (sst_pkg::EntryW),
    .Depth (MaxEntries)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  assign busy_o        = seq_busy;
  assign valid_o       = valid_q;
  assign status_o      = result_q.status;
  assign position_o    = result_q.position;
  assign total_o       = result_q.total;
  assign entry_count_o = result_q.entry_count;

endmodule

FILE: hw/rtl/sst_checker.sv
`timescale 1ns / 1ps
// Port-level checker for the sorted score table, bound to the top level.
// Depends on sst_pkg and sorted_score_table_top.
module sst_checker (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        start_i,
  input logic                        busy_o,
  input logic                        valid_o,
  input logic [1:0]                  status_o,
  input logic [sst_pkg::PosW-1:0]    position_o,
  input logic [sst_pkg::PosW-1:0]    entry_count_o
);

  // An accepted item keeps the block busy in the following cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |=> busy_o)
    else $error("accepted item did not raise busy");

  // A result only appears once the block is free again.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> !busy_o)
    else $error("result shown while busy");

  // Each item is accepted in idle and completes in a later state, so results never come back to back.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |=> !valid_o)
    else $error("result strobe longer than one cycle");

  // A failed command reports no position.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && (status_o != sst_pkg::ST_OK)) |-> (position_o == '0))
    else $error("position given with a failing status");

  // A successful position never lies more than one beyond the new entry count;
  // after a remove that bound is the table's end as it stood before the item.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && (status_o == sst_pkg::ST_OK)) |->
      ({1'b0, position_o} <= ({1'b0, entry_count_o} + 10'd1)))
    else $error("position beyond entry count");

endmodule

bind sorted_score_table_top sst_checker u_sst_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .start_i       (start_i),
  .busy_o        (busy_o),
  .valid_o       (valid_o),
  .status_o      (status_o),
  .position_o    (position_o),
  .entry_count_o (entry_count_o)
);
